@@ design/gcjq_pkg.sv @@
// ----------------------------------------------------------------------------
// gcjq_pkg
// shared types, codes and defaults of the group completion join queue
// ----------------------------------------------------------------------------
package gcjq_pkg;

  localparam int GROUPS_DEF      = 4;
  localparam int MEMBERS_DEF     = 16;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int MAX_OUT         = 16;
  localparam int KEY_W           = 32;
  localparam int SIZE_W          = 5;

  localparam logic [1:0] REQ_QUEUE = 2'd0;
  localparam logic [1:0] REQ_GET   = 2'd1;
  localparam logic [1:0] REQ_DEQ   = 2'd2;

  localparam logic [2:0] ST_QUEUED   = 3'd0;
  localparam logic [2:0] ST_COMPLETE = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_SORTED   = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;
  localparam logic [2:0] ST_DEQUEUED = 3'd5;

  typedef struct packed {
    logic             v;
    logic [KEY_W-1:0] key;
  } slot_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } sort_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE, S_QWR, S_GRD, S_GKEY, S_GINS, S_GDRAIN, S_GOUT, S_DRD, S_DWR, S_RES
  } state_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s,
                                                 input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] r;
    r = s;
    if (r == '0) r = SIZE_W'(1);
    if (r > lim) r = lim;
    return r;
  endfunction

endpackage

@@ design/gcjq_ram.sv @@
// ----------------------------------------------------------------------------
// gcjq_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gcjq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/gcjq_cell.sv @@
// ----------------------------------------------------------------------------
// gcjq_cell
// one cell of the insertion sort chain: keeps the smaller key, passes the other
// ----------------------------------------------------------------------------
module gcjq_cell
  import gcjq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  sort_ctl_t ctl,
  input  slot_t     left_in,
  input  slot_t     right_held,
  output slot_t     pass_out,
  output slot_t     held
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      held.v     <= 1'b0;
      pass_out.v <= 1'b0;
    end else if (ctl.shift) begin
      held       <= right_held;
      pass_out.v <= 1'b0;
    end else if (left_in.v) begin
      if (!held.v || left_in.key < held.key) begin
        held     <= left_in;
        pass_out <= held;
      end else begin
        pass_out <= left_in;
      end
    end else begin
      pass_out.v <= 1'b0;
    end
  end

endmodule

@@ design/group_completion_join_queue_core.sv @@
// ----------------------------------------------------------------------------
// group_completion_join_queue_core
// per group and member key fifos with completion latch and sorted readout
// ----------------------------------------------------------------------------
// One request at a time. A queue request reads the fifo pointer, writes key and
// pointer, then gives its result word; a dequeue reads and writes the pointer of
// each member of the latched group, then gives its result; a get reads the
// pointer, reads the key and inserts it into the sort chain for each member,
// lets the chain settle, then gives one sorted word per cycle while the output
// is not stalled. Fifo pointers and keys live in rams with one read port each;
// fifo valid and non empty flags are held in flops, so no clearing pass follows reset.
module group_completion_join_queue_core
  import gcjq_pkg::*;
#(
  parameter int GROUPS      = GROUPS_DEF,
  parameter int MEMBERS     = MEMBERS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic [1:0]        group_id,
  input  logic [3:0]        member_rank,
  input  logic [4:0]        group_size,
  input  logic [KEY_W-1:0]  event_key,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [1:0]        out_group,
  output logic [KEY_W-1:0]  out_key,
  output logic              last
);

  localparam int NF    = GROUPS * MEMBERS;
  localparam int FW    = $clog2(NF);
  localparam int NK    = NF * QUEUE_DEPTH;
  localparam int KW    = $clog2(NK);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int PW    = CW + HW;
  localparam int CELLS = (MEMBERS < MAX_OUT) ? MEMBERS : MAX_OUT;

  state_t state, state_next;

  logic [1:0]        rq_g;
  logic [SIZE_W-1:0] rq_size;
  logic [KEY_W-1:0]  rq_key;
  logic [FW-1:0]     rq_f;
  logic [1:0]        cg;
  logic              cvalid;
  logic [SIZE_W-1:0] cn;
  logic [SIZE_W-1:0] idx;
  logic [NF-1:0]     ne;
  logic [NF-1:0]     pv;
  logic [2:0]        res_st;
  logic [1:0]        res_g;

  logic              ptr_we;
  logic [FW-1:0]     ptr_waddr, ptr_raddr;
  logic [PW-1:0]     ptr_wdata, ptr_rdata;
  logic              key_we;
  logic [KW-1:0]     key_waddr, key_raddr;
  logic [KEY_W-1:0]  key_rdata;

  logic              acc, free, bad, get_ok, complete, last_idx;
  logic [SIZE_W-1:0] in_size;
  logic [FW-1:0]     in_f, cur_f, data_f;
  logic [CW-1:0]     p_cnt;
  logic [HW-1:0]     p_hd, slot, hd_inc;
  logic              out_load;
  logic [2:0]        ld_st;
  logic [1:0]        ld_g;
  logic [KEY_W-1:0]  ld_key;
  logic              ld_last;
  sort_ctl_t         sctl;
  slot_t             ins;
  slot_t             pass [CELLS];
  slot_t             held [CELLS];

  function automatic logic grp_full(input logic [NF-1:0] v, input logic [1:0] gg,
                                    input logic [SIZE_W-1:0] n);
    logic [MEMBERS-1:0] seg;
    logic               f;
    seg = v[32'(gg) * MEMBERS +: MEMBERS];
    f   = 1'b1;
    for (int r = 0; r < MEMBERS; r++) begin
      if (r < 32'(n) && !seg[r]) f = 1'b0;
    end
    return f;
  endfunction

  function automatic logic [HW-1:0] mod_qd(input logic [CW:0] s);
    return HW'((32'(s) >= QUEUE_DEPTH) ? 32'(s) - QUEUE_DEPTH : 32'(s));
  endfunction

  gcjq_ram #(.WIDTH(PW), .DEPTH(NF)) u_ptr_ram (
    .clk(clk), .we(ptr_we), .waddr(ptr_waddr), .wdata(ptr_wdata),
    .raddr(ptr_raddr), .rdata(ptr_rdata)
  );

  gcjq_ram #(.WIDTH(KEY_W), .DEPTH(NK)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(rq_key),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    gcjq_cell u_cell (
      .clk(clk), .rst(rst), .ctl(sctl),
      .left_in((i == 0) ? ins : pass[(i == 0) ? 0 : i - 1]),
      .right_held((i == CELLS - 1) ? slot_t'('0) : held[(i == CELLS - 1) ? i : i + 1]),
      .pass_out(pass[i]), .held(held[i])
    );
  end

  assign acc      = in_valid && in_ready;
  assign free     = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign in_size  = eff_size(group_size, SIZE_W'(CELLS));
  assign in_f     = FW'(32'(group_id) * MEMBERS + 32'(member_rank));
  assign bad      = (32'(group_id) >= GROUPS) || ({1'b0, member_rank} >= in_size);
  assign cur_f    = FW'(32'(cg) * MEMBERS + 32'(idx));
  assign data_f   = (state == S_QWR) ? rq_f : cur_f;
  assign p_cnt    = pv[data_f] ? ptr_rdata[PW-1:HW] : '0;
  assign p_hd     = pv[data_f] ? ptr_rdata[HW-1:0] : '0;
  assign slot     = mod_qd((CW+1)'(p_hd) + (CW+1)'(p_cnt));
  assign hd_inc   = mod_qd((CW+1)'(p_hd) + (CW+1)'(1));
  assign get_ok   = cvalid && grp_full(ne, cg, cn) && (cn != '0);
  assign complete = grp_full(ne | (NF'(1) << rq_f), rq_g, rq_size);
  assign last_idx = (SIZE_W'(idx + SIZE_W'(1)) == cn);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ptr_we     = 1'b0;
    ptr_waddr  = data_f;
    ptr_wdata  = '0;
    ptr_raddr  = cur_f;
    key_we     = 1'b0;
    key_waddr  = KW'(32'(rq_f) * QUEUE_DEPTH + 32'(slot));
    key_raddr  = KW'(32'(cur_f) * QUEUE_DEPTH + 32'(p_hd));
    sctl       = '0;
    ins.v      = 1'b0;
    ins.key    = key_rdata;
    out_load   = 1'b0;
    ld_st      = res_st;
    ld_g       = res_g;
    ld_key     = '0;
    ld_last    = 1'b1;
    unique case (state)
      S_IDLE: begin
        ptr_raddr = in_f;
        if (acc) begin
          unique case (req_type)
            REQ_QUEUE: state_next = bad ? S_RES : S_QWR;
            REQ_GET: begin
              sctl.clear = 1'b1;
              state_next = get_ok ? S_GRD : S_RES;
            end
            REQ_DEQ: state_next = cvalid ? S_DRD : S_RES;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_QWR: begin
        if (32'(p_cnt) < QUEUE_DEPTH) begin
          key_we    = 1'b1;
          ptr_we    = 1'b1;
          ptr_wdata = {CW'(p_cnt + CW'(1)), p_hd};
        end
        state_next = S_RES;
      end
      S_GRD:  state_next = S_GKEY;
      S_GKEY: state_next = S_GINS;
      S_GINS: begin
        ins.v      = 1'b1;
        state_next = last_idx ? S_GDRAIN : S_GRD;
      end
      S_GDRAIN: begin
        if (idx == SIZE_W'(CELLS - 1)) state_next = S_GOUT;
      end
      S_GOUT: begin
        if (free) begin
          out_load   = 1'b1;
          sctl.shift = 1'b1;
          ld_st      = ST_SORTED;
          ld_g       = cg;
          ld_key     = held[0].key;
          ld_last    = last_idx;
          if (last_idx) state_next = S_IDLE;
        end
      end
      S_DRD: state_next = S_DWR;
      S_DWR: begin
        if (p_cnt != '0) begin
          ptr_we    = 1'b1;
          ptr_wdata = {CW'(p_cnt - CW'(1)), hd_inc};
        end
        state_next = last_idx ? S_RES : S_DRD;
      end
      S_RES: begin
        if (free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cvalid <= 1'b0;
      cg     <= '0;
      cn     <= '0;
      ne     <= '0;
      pv     <= '0;
      idx    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          idx <= '0;
          if (acc) begin
            rq_g    <= group_id;
            rq_size <= in_size;
            rq_key  <= event_key;
            rq_f    <= in_f;
            res_g   <= '0;
            res_st  <= ST_NONE;
            if (req_type == REQ_QUEUE && bad) begin
              res_st <= ST_DROPPED;
              res_g  <= group_id;
            end
          end
        end
        S_QWR: begin
          res_g <= rq_g;
          if (32'(p_cnt) >= QUEUE_DEPTH) begin
            res_st <= ST_DROPPED;
          end else begin
            ne[rq_f] <= 1'b1;
            pv[rq_f] <= 1'b1;
            if (rq_g == cg) cn <= rq_size;
            if (complete) begin
              cvalid <= 1'b1;
              cg     <= rq_g;
              cn     <= rq_size;
              res_st <= ST_COMPLETE;
            end else begin
              res_st <= ST_QUEUED;
            end
          end
        end
        S_GINS: idx <= last_idx ? '0 : SIZE_W'(idx + SIZE_W'(1));
        S_GDRAIN: idx <= (idx == SIZE_W'(CELLS - 1)) ? '0 : SIZE_W'(idx + SIZE_W'(1));
        S_GOUT: if (free) idx <= SIZE_W'(idx + SIZE_W'(1));
        S_DWR: begin
          if (p_cnt == CW'(1)) ne[cur_f] <= 1'b0;
          idx <= SIZE_W'(idx + SIZE_W'(1));
          if (last_idx) begin
            cvalid <= 1'b0;
            res_st <= ST_DEQUEUED;
            res_g  <= cg;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status    <= ld_st;
      out_group <= ld_g;
      out_key   <= ld_key;
      last      <= ld_last;
    end
  end

endmodule

@@ design/gcjq_checker.sv @@
// ----------------------------------------------------------------------------
// gcjq_checker
// port level checks of the group completion join queue
// ----------------------------------------------------------------------------
module gcjq_checker
  import gcjq_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [2:0]       status,
  input logic [1:0]       out_group,
  input logic [KEY_W-1:0] out_key,
  input logic             last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(status))
    else $error("output word changed while stalled");

  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_SORTED |-> last && out_key == '0)
    else $error("non sorted word not final or key not zero");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input taken while a sorted list is pending");

  a_none_grp: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NONE |-> out_group == '0)
    else $error("none ready word with group set");

endmodule

bind group_completion_join_queue_core gcjq_checker u_gcjq_checker (.*);
